/* hdl/b64d_pkg.sv */
// Shared types and constants for the base64 stream decoder.
package b64d_pkg;

    localparam logic [5:0] LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_BASE = 6'd52;
    localparam logic [5:0] PLUS_CODE  = 6'd62;
    localparam logic [5:0] SLASH_CODE = 6'd63;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    localparam logic CMD_CHAR   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } entry_t;

    // Results caused by one input item, entry 0 delivered first.
    typedef struct packed {
        logic [1:0]       n;
        entry_t [2:0]     e;
    } group_t;

endpackage

/* hdl/b64d_core.sv */
// Decoder state and per-character decode into a group of results.
module b64d_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic                 cmd,
    input  logic [7:0]           ch,
    output b64d_pkg::group_t     grp
);

    logic [23:0] acc_reg, acc_next;
    logic [1:0]  gcnt_reg, gcnt_next;
    logic [1:0]  pad_reg, pad_next;
    logic        err_reg, err_next;

    logic        is_upper, is_lower, is_digit, is_plus, is_slash, is_alpha, is_blank;
    logic [5:0]  sixbit;
    logic [23:0] acc_shift;
    logic        bad;

    always_comb
    begin
        is_upper = (ch >= 8'h41) && (ch <= 8'h5A);
        is_lower = (ch >= 8'h61) && (ch <= 8'h7A);
        is_digit = (ch >= 8'h30) && (ch <= 8'h39);
        is_plus  = (ch == b64d_pkg::CH_PLUS);
        is_slash = (ch == b64d_pkg::CH_SLASH);
        is_alpha = is_upper || is_lower || is_digit || is_plus || is_slash;
        // space, tab, LF, VT, FF, CR
        is_blank = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));

        priority if (is_upper)
            sixbit = 6'(ch - 8'h41);
        else if (is_lower)
            sixbit = 6'(ch - 8'h61) + b64d_pkg::LOWER_BASE;
        else if (is_digit)
            sixbit = 6'(ch - 8'h30) + b64d_pkg::DIGIT_BASE;
        else if (is_plus)
            sixbit = b64d_pkg::PLUS_CODE;
        else
            sixbit = b64d_pkg::SLASH_CODE;

        acc_shift = {acc_reg[17:0], sixbit};
        bad       = err_reg || (pad_reg == 2'd3) || (gcnt_reg == 2'd1);
    end

    always_comb
    begin
        acc_next  = acc_reg;
        gcnt_next = gcnt_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        grp       = '0;

        if (cmd == b64d_pkg::CMD_FINISH)
        begin
            acc_next  = '0;
            gcnt_next = '0;
            pad_next  = '0;
            err_next  = 1'b0;
            if (!bad && gcnt_reg == 2'd2)
            begin
                grp.n         = 2'd2;
                grp.e[0].kind = b64d_pkg::KIND_DATA;
                grp.e[0].data = acc_reg[11:4];
                grp.e[1].kind = b64d_pkg::KIND_OK;
            end
            else if (!bad && gcnt_reg == 2'd3)
            begin
                grp.n         = 2'd3;
                grp.e[0].kind = b64d_pkg::KIND_DATA;
                grp.e[0].data = acc_reg[17:10];
                grp.e[1].kind = b64d_pkg::KIND_DATA;
                grp.e[1].data = acc_reg[9:2];
                grp.e[2].kind = b64d_pkg::KIND_OK;
            end
            else
            begin
                grp.n         = 2'd1;
                grp.e[0].kind = bad ? b64d_pkg::KIND_ERR : b64d_pkg::KIND_OK;
            end
        end
        else if (err_reg || is_blank)
        begin
            // skipped
        end
        else if (ch == b64d_pkg::CH_PAD)
        begin
            if (pad_reg != 2'd3)
                pad_next = pad_reg + 2'd1;
        end
        else if (pad_reg != 2'd0 || !is_alpha)
        begin
            err_next = 1'b1;
        end
        else if (gcnt_reg == 2'd3)
        begin
            acc_next      = '0;
            gcnt_next     = '0;
            grp.n         = 2'd3;
            grp.e[0].kind = b64d_pkg::KIND_DATA;
            grp.e[0].data = acc_shift[23:16];
            grp.e[1].kind = b64d_pkg::KIND_DATA;
            grp.e[1].data = acc_shift[15:8];
            grp.e[2].kind = b64d_pkg::KIND_DATA;
            grp.e[2].data = acc_shift[7:0];
        end
        else
        begin
            acc_next  = acc_shift;
            gcnt_next = gcnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            gcnt_reg <= '0;
            pad_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else if (take)
        begin
            acc_reg  <= acc_next;
            gcnt_reg <= gcnt_next;
            pad_reg  <= pad_next;
            err_reg  <= err_next;
        end
    end

endmodule

/* hdl/b64d_out.sv */
// Result register: holds one result group and sends it one entry per transfer.
module b64d_out
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  b64d_pkg::group_t     grp,
    output logic                 can_load,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [7:0]           data_byte,
    output logic                 last
);

    logic [1:0]             rem_reg, rem_next;
    logic [1:0]             idx_reg, idx_next;
    b64d_pkg::entry_t [2:0] ent_reg;
    logic                   xfer;

    assign out_valid = (rem_reg != 2'd0);
    assign xfer      = out_valid && out_ready;
    // free now, or the final entry leaves this cycle
    assign can_load  = (rem_reg == 2'd0) || (rem_reg == 2'd1 && out_ready);

    assign kind      = ent_reg[idx_reg].kind;
    assign data_byte = ent_reg[idx_reg].data;
    assign last      = (rem_reg == 2'd1);

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (xfer)
        begin
            rem_next = rem_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
        if (load && grp.n != 2'd0)
        begin
            rem_next = grp.n;
            idx_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && grp.n != 2'd0)
            ent_reg <= grp.e;
    end

endmodule

/* hdl/base64_stream_decoder_unit.sv */
// Top level of the base64 stream decoder.
// Streaming Base64 decoder, one text byte (or a finish command) per transfer.
// Every input item is decoded in the cycle it is accepted; its results (none,
// or up to three: data bytes followed on finish by a status word) go into a
// result register and leave one per output transfer, last marking the final
// one of each item. With a ready receiver, items that yield at most one result
// are taken every cycle; after an item that yields two or three results the
// next item is taken as the final one of them leaves the result register. A
// receiver that holds off stalls the input once a result is waiting. An error
// status means the bytes already released for this stream must be discarded.
// Finish clears all decoder state.
module base64_stream_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] data_byte,
    output logic       last
);

    b64d_pkg::group_t grp;
    logic             take;
    logic             can_load;

    assign in_ready = can_load;
    assign take     = in_valid && in_ready;

    b64d_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .cmd   (cmd),
        .ch    (ch),
        .grp   (grp)
    );

    b64d_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .grp       (grp),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .last      (last)
    );

endmodule
